// ===== hw/rtl/jcd_pkg.sv =====
// Package for the Japanese charset detector: charset codes, scanner states,
// UTF-8 bound codes and byte constants. No dependencies.
package jcd_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CS_W            = 3;
    localparam int VERDICT_W       = 2;

    // charset result codes
    localparam logic [CS_W-1:0] CS_ASCII = 3'd0;
    localparam logic [CS_W-1:0] CS_EUC   = 3'd1;
    localparam logic [CS_W-1:0] CS_JIS   = 3'd2;
    localparam logic [CS_W-1:0] CS_SJIS  = 3'd3;
    localparam logic [CS_W-1:0] CS_UTF8  = 3'd4;

    // early verdict codes (low bits of the charset code)
    localparam logic [VERDICT_W-1:0] VD_NONE = 2'd0;
    localparam logic [VERDICT_W-1:0] VD_EUC  = 2'd1;
    localparam logic [VERDICT_W-1:0] VD_JIS  = 2'd2;
    localparam logic [VERDICT_W-1:0] VD_SJIS = 2'd3;

    // UTF-8 continuation bound adjustments
    localparam logic [1:0] U8_LIM_NONE = 2'd0;
    localparam logic [1:0] U8_LIM_LO   = 2'd1;
    localparam logic [1:0] U8_LIM_HI   = 2'd2;

    localparam logic [7:0] BYTE_ESC    = 8'd27;
    localparam logic [7:0] BYTE_SS2    = 8'd142;
    localparam logic [7:0] BYTE_DOLLAR = 8'h24;
    localparam logic [7:0] BYTE_AT     = 8'h40;
    localparam logic [7:0] BYTE_B      = 8'h42;

    typedef enum logic [5:0] {
        SCAN_NORMAL     = 6'b000001,
        SCAN_ESC        = 6'b000010,
        SCAN_ESC_DOLLAR = 6'b000100,
        SCAN_SS2        = 6'b001000,
        SCAN_LEAD       = 6'b010000,
        SCAN_STOP       = 6'b100000
    } t_scan;

endpackage

// ===== hw/rtl/jcd_in_if.sv =====
// Input channel of the charset detector: one text byte and a last flag per beat.
// Depends on nothing.
interface jcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source(output valid, output text_byte, output is_last, input ready);
    modport sink(input valid, input text_byte, input is_last, output ready);
endinterface

// ===== hw/rtl/jcd_out_if.sv =====
// Output channel of the charset detector: one charset code per beat.
// Depends on jcd_pkg for the code width.
interface jcd_out_if;
    logic                     valid;
    logic                     ready;
    logic [jcd_pkg::CS_W-1:0] charset;

    modport source(output valid, output charset, input ready);
    modport sink(input valid, input charset, output ready);
endinterface

// ===== hw/rtl/japanese_charset_detector.sv =====
// Japanese charset detector top level: input register, byte trackers, result register.
// Depends on jcd_pkg, jcd_in_if and jcd_out_if.
//
//  channel | dir | payload              | beat
//  i_in    | in  | text_byte, is_last   | one byte of the string
//  o_out   | out | charset              | one code per string, on its last byte
//
// One byte per cycle sustained unless a last byte is held; a byte is registered, then all
// trackers update on a non-zero byte as it leaves the input register, and the code of a
// last byte lands in the result register at that point.
// Synchronous active-low reset clears all tracker state; no clearing pass.
// Non-last bytes keep flowing while a result waits; a last byte holds in the input
// register only while the result register is full and o_out.ready is low.
module japanese_charset_detector #(
    parameter int COUNT_WIDTH = jcd_pkg::COUNT_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    jcd_in_if.sink   i_in,
    jcd_out_if.source o_out
);
    import jcd_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // result register
    logic            r_out_valid;
    logic [CS_W-1:0] r_cs;

    // tracker state
    t_scan                  r_mode, n_mode;
    logic [VERDICT_W-1:0]   r_verdict, n_verdict;
    logic                   r_vvalid, n_vvalid;
    logic [7:0]             r_sjis_prev, r_euc_prev;
    logic                   r_sjis_skip, n_sjis_skip;
    logic                   r_euc_skip, n_euc_skip;
    logic [COUNT_WIDTH-1:0] r_sjis_cnt, n_sjis_cnt;
    logic [COUNT_WIDTH-1:0] r_euc_cnt, n_euc_cnt;
    logic [1:0]             r_u8_pend, n_u8_pend;
    logic [1:0]             r_u8_lim, n_u8_lim;
    logic                   r_u8_bad, n_u8_bad;

    logic            advance;
    logic            byte_nz;
    logic [7:0]      u8_lo, u8_hi;
    logic [CS_W-1:0] n_cs;

    assign byte_nz    = (r_byte != 8'd0);
    assign advance    = r_in_valid && (!r_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid   = r_out_valid;
    assign o_out.charset = r_cs;

    // first-pass scanner
    always_comb begin
        n_mode    = r_mode;
        n_verdict = r_verdict;
        n_vvalid  = r_vvalid;
        if (byte_nz) begin
            case (r_mode)
                SCAN_NORMAL: begin
                    if (r_byte == BYTE_ESC) begin
                        n_mode = SCAN_ESC;
                    end else if (r_byte inside {[8'h81:8'h8d], [8'h8f:8'h9f]}) begin
                        n_verdict = VD_SJIS;
                        n_vvalid  = 1'b1;
                        n_mode    = SCAN_STOP;
                    end else if (r_byte == BYTE_SS2) begin
                        n_mode = SCAN_SS2;
                    end else if (r_byte inside {[8'ha1:8'hdf]}) begin
                        n_mode = SCAN_LEAD;
                    end else if (r_byte inside {[8'hf0:8'hfe]}) begin
                        n_verdict = VD_EUC;
                        n_vvalid  = 1'b1;
                        n_mode    = SCAN_STOP;
                    end
                end
                SCAN_ESC: begin
                    n_mode = (r_byte == BYTE_DOLLAR) ? SCAN_ESC_DOLLAR : SCAN_NORMAL;
                end
                SCAN_ESC_DOLLAR: begin
                    if (r_byte == BYTE_B || r_byte == BYTE_AT) begin
                        n_verdict = VD_JIS;
                        n_vvalid  = 1'b1;
                        n_mode    = SCAN_STOP;
                    end else begin
                        n_mode = SCAN_NORMAL;
                    end
                end
                SCAN_SS2: begin
                    if (r_byte inside {[8'h40:8'h7e], [8'h80:8'ha0], [8'he0:8'hfc]}) begin
                        n_verdict = VD_SJIS;
                        n_vvalid  = 1'b1;
                        n_mode    = SCAN_STOP;
                    end else if (r_byte inside {[8'ha1:8'hdf]}) begin
                        n_mode = SCAN_STOP;
                    end else begin
                        n_mode = SCAN_NORMAL;
                    end
                end
                SCAN_LEAD: begin
                    if (r_byte inside {8'ha0, [8'he0:8'hfe]}) begin
                        n_verdict = VD_EUC;
                        n_vvalid  = 1'b1;
                        n_mode    = SCAN_STOP;
                    end else begin
                        n_mode = SCAN_NORMAL;
                    end
                end
                SCAN_STOP: begin
                    n_mode = SCAN_STOP;
                end
                default: begin
                    n_mode = SCAN_NORMAL;
                end
            endcase
        end
    end

    // pair counters, saturating; the partner byte of a pair is not tested
    always_comb begin
        n_sjis_skip = r_sjis_skip;
        n_sjis_cnt  = r_sjis_cnt;
        n_euc_skip  = r_euc_skip;
        n_euc_cnt   = r_euc_cnt;
        if (byte_nz) begin
            if (r_sjis_skip) begin
                n_sjis_skip = 1'b0;
            end else if ((r_sjis_prev inside {[8'h81:8'h9f], [8'he0:8'hfc]}) &&
                         (r_byte inside {[8'h40:8'h7e], [8'h80:8'hfc]})) begin
                if (r_sjis_cnt != '1) begin
                    n_sjis_cnt = r_sjis_cnt + 1'b1;
                end
                n_sjis_skip = 1'b1;
            end
            if (r_euc_skip) begin
                n_euc_skip = 1'b0;
            end else if ((r_euc_prev inside {[8'ha1:8'hfe]}) &&
                         (r_byte inside {[8'ha1:8'hfe]})) begin
                if (r_euc_cnt != '1) begin
                    n_euc_cnt = r_euc_cnt + 1'b1;
                end
                n_euc_skip = 1'b1;
            end
        end
    end

    // strict UTF-8 check
    always_comb begin
        n_u8_pend = r_u8_pend;
        n_u8_lim  = r_u8_lim;
        n_u8_bad  = r_u8_bad;
        u8_lo     = 8'h80;
        u8_hi     = 8'hbf;
        if (r_u8_lim == U8_LIM_LO) begin
            u8_lo = (r_u8_pend == 2'd2) ? 8'ha0 : 8'h90;
        end else if (r_u8_lim == U8_LIM_HI) begin
            u8_hi = (r_u8_pend == 2'd2) ? 8'h9f : 8'h8f;
        end
        if (byte_nz && !r_u8_bad) begin
            n_u8_lim = U8_LIM_NONE;
            if (r_u8_pend == 2'd0) begin
                if (r_byte[7] == 1'b0) begin
                    n_u8_pend = 2'd0;
                end else if (r_byte inside {[8'hc2:8'hdf]}) begin
                    n_u8_pend = 2'd1;
                end else if (r_byte inside {[8'he0:8'hef]}) begin
                    n_u8_pend = 2'd2;
                    if (r_byte == 8'he0) n_u8_lim = U8_LIM_LO;
                    if (r_byte == 8'hed) n_u8_lim = U8_LIM_HI;
                end else if (r_byte inside {[8'hf0:8'hf4]}) begin
                    n_u8_pend = 2'd3;
                    if (r_byte == 8'hf0) n_u8_lim = U8_LIM_LO;
                    if (r_byte == 8'hf4) n_u8_lim = U8_LIM_HI;
                end else begin
                    n_u8_bad = 1'b1;
                end
            end else if (r_byte < u8_lo || r_byte > u8_hi) begin
                n_u8_bad  = 1'b1;
                n_u8_pend = 2'd0;
            end else begin
                n_u8_pend = r_u8_pend - 2'd1;
            end
        end
    end

    // final decision, taken on the updated state
    always_comb begin
        if (!n_u8_bad && n_u8_pend == 2'd0) begin
            n_cs = CS_UTF8;
        end else if (n_vvalid) begin
            n_cs = {1'b0, n_verdict};
        end else if (n_sjis_cnt > n_euc_cnt) begin
            n_cs = CS_SJIS;
        end else if (n_euc_cnt != '0) begin
            n_cs = CS_EUC;
        end else begin
            n_cs = CS_ASCII;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.text_byte;
            r_last <= i_in.is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_cs <= n_cs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_last)) begin
            r_mode      <= SCAN_NORMAL;
            r_verdict   <= VD_NONE;
            r_vvalid    <= 1'b0;
            r_sjis_prev <= 8'd0;
            r_sjis_skip <= 1'b0;
            r_euc_prev  <= 8'd0;
            r_euc_skip  <= 1'b0;
            r_sjis_cnt  <= '0;
            r_euc_cnt   <= '0;
            r_u8_pend   <= 2'd0;
            r_u8_lim    <= U8_LIM_NONE;
            r_u8_bad    <= 1'b0;
        end else if (advance && byte_nz) begin
            r_mode      <= n_mode;
            r_verdict   <= n_verdict;
            r_vvalid    <= n_vvalid;
            r_sjis_prev <= r_byte;
            r_sjis_skip <= n_sjis_skip;
            r_euc_prev  <= r_byte;
            r_euc_skip  <= n_euc_skip;
            r_sjis_cnt  <= n_sjis_cnt;
            r_euc_cnt   <= n_euc_cnt;
            r_u8_pend   <= n_u8_pend;
            r_u8_lim    <= n_u8_lim;
            r_u8_bad    <= n_u8_bad;
        end
    end

endmodule

// ===== hw/rtl/jcd_checker.sv =====
// Port-level checks for the Japanese charset detector, and the bind that attaches them.
// Depends on jcd_pkg and the japanese_charset_detector top level.
module jcd_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_in_last,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [jcd_pkg::CS_W-1:0] i_charset
);
    import jcd_pkg::*;

    // last beats taken in but not yet delivered as results
    logic [1:0] r_pend;
    logic       last_in;
    logic       res_out;

    assign last_in = i_in_valid && i_in_ready && i_in_last;
    assign res_out = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + {1'b0, last_in} - {1'b0, res_out};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_charset))
        else $error("result beat dropped or changed while stalled");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_charset <= CS_UTF8)
        else $error("charset code out of range");

    a_result_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("result without a pending last byte");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'd2)
        else $error("more last bytes in flight than stages");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with result register empty");

endmodule

bind japanese_charset_detector jcd_checker u_jcd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_in_last  (i_in.is_last),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_charset  (o_out.charset)
);

// ===== dv/tb_japanese_charset_detector.sv =====
`timescale 1ns / 1ps
// Self-checking bench for japanese_charset_detector: queue-fed byte driver,
// clocked result monitor and a bit-true charset predictor.
// Depends on jcd_pkg, jcd_in_if, jcd_out_if and the detector RTL.
module tb_japanese_charset_detector;
    import jcd_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int CNT_W       = COUNT_WIDTH_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_text_beat;

    logic clk;
    logic rst_n;

    jcd_in_if  in_ch ();
    jcd_out_if out_ch ();

    japanese_charset_detector uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    t_text_beat       pending_beats[$];
    logic [CS_W-1:0]  expected_cs[$];
    logic [7:0]       str_q[$];
    int               queued_beats;
    int               err_cnt;
    int               tx_idle;
    int               rx_idle;
    bit               tx_pause;
    bit               hold_req;
    int               hold_left;
    bit               in_took;

    // predictor state
    t_scan                scan_st;
    logic [VERDICT_W-1:0] verdict;
    logic                 verdict_ok;
    logic [7:0]           sj_prev;
    logic                 sj_skip;
    logic [7:0]           eu_prev;
    logic                 eu_skip;
    logic [CNT_W-1:0]     sj_cnt;
    logic [CNT_W-1:0]     eu_cnt;
    logic [1:0]           u8_left;
    logic [1:0]           u8_lim;
    logic                 u8_bad;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic clear_tracker();
        scan_st    = SCAN_NORMAL;
        verdict    = VD_NONE;
        verdict_ok = 1'b0;
        sj_prev    = 8'h00;
        sj_skip    = 1'b0;
        eu_prev    = 8'h00;
        eu_skip    = 1'b0;
        sj_cnt     = '0;
        eu_cnt     = '0;
        u8_left    = 2'd0;
        u8_lim     = U8_LIM_NONE;
        u8_bad     = 1'b0;
    endtask

    task automatic settle_verdict(input logic [VERDICT_W-1:0] v);
        verdict    = v;
        verdict_ok = 1'b1;
        scan_st    = SCAN_STOP;
    endtask

    // Advance all four trackers by one byte; a last byte yields the expected code.
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        logic [7:0]      lo;
        logic [7:0]      hi;
        logic [CS_W-1:0] cs;

        case (scan_st)
            SCAN_NORMAL: begin
                if (b == BYTE_ESC) begin
                    scan_st = SCAN_ESC;
                end else if ((b >= 8'h81 && b <= 8'h8d) || (b >= 8'h8f && b <= 8'h9f)) begin
                    settle_verdict(VD_SJIS);
                end else if (b == BYTE_SS2) begin
                    scan_st = SCAN_SS2;
                end else if (b >= 8'ha1 && b <= 8'hdf) begin
                    scan_st = SCAN_LEAD;
                end else if (b >= 8'hf0 && b <= 8'hfe) begin
                    settle_verdict(VD_EUC);
                end
            end
            SCAN_ESC: begin
                scan_st = (b == BYTE_DOLLAR) ? SCAN_ESC_DOLLAR : SCAN_NORMAL;
            end
            SCAN_ESC_DOLLAR: begin
                if (b == BYTE_B || b == BYTE_AT) settle_verdict(VD_JIS);
                else scan_st = SCAN_NORMAL;
            end
            SCAN_SS2: begin
                if ((b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'ha0) ||
                    (b >= 8'he0 && b <= 8'hfc)) begin
                    settle_verdict(VD_SJIS);
                end else if (b >= 8'ha1 && b <= 8'hdf) begin
                    scan_st = SCAN_STOP;
                end else begin
                    scan_st = SCAN_NORMAL;
                end
            end
            SCAN_LEAD: begin
                if (b == 8'ha0 || (b >= 8'he0 && b <= 8'hfe)) settle_verdict(VD_EUC);
                else scan_st = SCAN_NORMAL;
            end
            default: ;
        endcase

        // pair counters: the partner byte of a counted pair is never a lead
        if (sj_skip) begin
            sj_skip = 1'b0;
        end else if (((sj_prev >= 8'h81 && sj_prev <= 8'h9f) ||
                      (sj_prev >= 8'he0 && sj_prev <= 8'hfc)) &&
                     ((b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'hfc))) begin
            if (sj_cnt != '1) sj_cnt++;
            sj_skip = 1'b1;
        end
        sj_prev = b;

        if (eu_skip) begin
            eu_skip = 1'b0;
        end else if (eu_prev >= 8'ha1 && eu_prev <= 8'hfe && b >= 8'ha1 && b <= 8'hfe) begin
            if (eu_cnt != '1) eu_cnt++;
            eu_skip = 1'b1;
        end
        eu_prev = b;

        if (!u8_bad) begin
            if (u8_left == 2'd0) begin
                u8_lim = U8_LIM_NONE;
                if (b < 8'h80) begin
                    u8_left = 2'd0;
                end else if (b >= 8'hc2 && b <= 8'hdf) begin
                    u8_left = 2'd1;
                end else if (b >= 8'he0 && b <= 8'hef) begin
                    u8_left = 2'd2;
                    if (b == 8'he0) u8_lim = U8_LIM_LO;
                    if (b == 8'hed) u8_lim = U8_LIM_HI;
                end else if (b >= 8'hf0 && b <= 8'hf4) begin
                    u8_left = 2'd3;
                    if (b == 8'hf0) u8_lim = U8_LIM_LO;
                    if (b == 8'hf4) u8_lim = U8_LIM_HI;
                end else begin
                    u8_bad = 1'b1;
                end
            end else begin
                // first continuation after E0/ED/F0/F4 has a narrowed range
                lo = 8'h80;
                hi = 8'hbf;
                if (u8_lim == U8_LIM_LO) lo = (u8_left == 2'd2) ? 8'ha0 : 8'h90;
                else if (u8_lim == U8_LIM_HI) hi = (u8_left == 2'd2) ? 8'h9f : 8'h8f;
                if (b < lo || b > hi) begin
                    u8_bad  = 1'b1;
                    u8_left = 2'd0;
                end else begin
                    u8_left--;
                end
                u8_lim = U8_LIM_NONE;
            end
        end

        if (last) begin
            if (!u8_bad && u8_left == 2'd0) cs = CS_UTF8;
            else if (verdict_ok) cs = {1'b0, verdict};
            else if (sj_cnt > eu_cnt) cs = CS_SJIS;
            else if (eu_cnt != '0) cs = CS_EUC;
            else cs = CS_ASCII;
            expected_cs.push_back(cs);
            clear_tracker();
        end
    endtask

    task automatic report_mismatch(input string what);
        err_cnt++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        int v;
        v = $urandom_range(hi, lo);
        return v[7:0];
    endfunction

    function automatic int pick_code_point();
        int bound_cp[8] = '{'h80, 'h7ff, 'h800, 'hd7ff, 'he000, 'hffff, 'h10000, 'h10ffff};
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 'h7f);
            1: return $urandom_range('h80, 'h7ff);
            2: return $urandom_range('h800, 'hd7ff);
            3: return $urandom_range('he000, 'hffff);
            4: return $urandom_range('h10000, 'h10ffff);
            default: return bound_cp[$urandom_range(0, 7)];
        endcase
    endfunction

    task automatic put_utf8(input int cp);
        if (cp < 'h80) begin
            str_q.push_back(cp[7:0]);
        end else if (cp < 'h800) begin
            str_q.push_back({3'b110, cp[10:6]});
            str_q.push_back({2'b10, cp[5:0]});
        end else if (cp < 'h10000) begin
            str_q.push_back({4'b1110, cp[15:12]});
            str_q.push_back({2'b10, cp[11:6]});
            str_q.push_back({2'b10, cp[5:0]});
        end else begin
            str_q.push_back({5'b11110, cp[20:18]});
            str_q.push_back({2'b10, cp[17:12]});
            str_q.push_back({2'b10, cp[11:6]});
            str_q.push_back({2'b10, cp[5:0]});
        end
    endtask

    task automatic put_noise(input int max_len);
        int n;
        n = $urandom_range(0, max_len);
        repeat (n) str_q.push_back(rand_byte(1, 255));
    endtask

    task automatic commit_string();
        t_text_beat t;
        foreach (str_q[i]) begin
            t.b    = str_q[i];
            t.last = (i == str_q.size() - 1);
            pending_beats.push_back(t);
            queued_beats++;
        end
        str_q.delete();
    endtask

    task automatic add_random_string();
        int n;
        int r;
        case ($urandom_range(0, 7))
            0: begin
                n = $urandom_range(1, 10);
                repeat (n) str_q.push_back(rand_byte(1, 255));
            end
            1: begin
                n = $urandom_range(1, 4);
                repeat (n) put_utf8(pick_code_point());
            end
            2: begin
                if ($urandom_range(0, 1)) put_utf8(pick_code_point());
                r = $urandom_range(0, 8);
                case (r)
                    0: begin  // overlong two-byte form
                        str_q.push_back(rand_byte('hc0, 'hc1));
                        str_q.push_back(rand_byte('h80, 'hbf));
                    end
                    1: begin  // overlong three-byte form
                        str_q.push_back(8'he0);
                        str_q.push_back(rand_byte('h80, 'h9f));
                        str_q.push_back(rand_byte('h80, 'hbf));
                    end
                    2: begin  // surrogate
                        str_q.push_back(8'hed);
                        str_q.push_back(rand_byte('ha0, 'hbf));
                        str_q.push_back(rand_byte('h80, 'hbf));
                    end
                    3: begin  // overlong four-byte form
                        str_q.push_back(8'hf0);
                        str_q.push_back(rand_byte('h80, 'h8f));
                        str_q.push_back(rand_byte('h80, 'hbf));
                        str_q.push_back(rand_byte('h80, 'hbf));
                    end
                    4: begin  // above U+10FFFF
                        str_q.push_back(8'hf4);
                        str_q.push_back(rand_byte('h90, 'hbf));
                        str_q.push_back(rand_byte('h80, 'hbf));
                        str_q.push_back(rand_byte('h80, 'hbf));
                    end
                    5: str_q.push_back(rand_byte('hf5, 'hff));
                    6: str_q.push_back(rand_byte('h80, 'hbf));
                    7: begin  // truncated at end of string
                        str_q.push_back(rand_byte('he1, 'hec));
                        if ($urandom_range(0, 1)) str_q.push_back(rand_byte('h80, 'hbf));
                    end
                    default: begin
                        str_q.push_back(rand_byte('hc2, 'hdf));
                        str_q.push_back(rand_byte(1, 'h7f));
                    end
                endcase
                if (r != 7 && $urandom_range(0, 1)) put_utf8(pick_code_point());
            end
            3: begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: str_q.push_back(rand_byte('h20, 'h7e));
                        3: begin
                            str_q.push_back(BYTE_SS2);
                            str_q.push_back(rand_byte('ha1, 'hdf));
                        end
                        default: begin
                            str_q.push_back(rand_byte('ha1, 'hfe));
                            str_q.push_back(rand_byte('ha1, 'hfe));
                        end
                    endcase
                end
            end
            4: begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 2) == 0) begin
                        str_q.push_back(rand_byte('h20, 'h7e));
                    end else begin
                        if ($urandom_range(0, 1)) str_q.push_back(rand_byte('h81, 'h9f));
                        else str_q.push_back(rand_byte('he0, 'hfc));
                        if ($urandom_range(0, 1)) str_q.push_back(rand_byte('h40, 'h7e));
                        else str_q.push_back(rand_byte('h80, 'hfc));
                    end
                end
            end
            5: begin
                if ($urandom_range(0, 1)) str_q.push_back(rand_byte('h20, 'h7e));
                str_q.push_back(BYTE_ESC);
                r = $urandom_range(0, 4);
                case (r)
                    0: begin str_q.push_back(BYTE_DOLLAR); str_q.push_back(BYTE_B); end
                    1: begin str_q.push_back(BYTE_DOLLAR); str_q.push_back(BYTE_AT); end
                    2: begin str_q.push_back(BYTE_DOLLAR); str_q.push_back(rand_byte(1, 255)); end
                    3: begin str_q.push_back(8'h28); str_q.push_back(BYTE_B); end
                    default: ;  // string ends inside the escape
                endcase
                if (r != 4) put_noise(4);
            end
            6: begin
                str_q.push_back(BYTE_SS2);
                if ($urandom_range(0, 3) != 0) str_q.push_back(rand_byte(1, 255));
                put_noise(3);
            end
            default: begin
                str_q.push_back(rand_byte('ha1, 'hdf));
                if ($urandom_range(0, 3) != 0) str_q.push_back(rand_byte(1, 255));
                put_noise(3);
            end
        endcase
        commit_string();
    endtask

    task automatic run_random(input int n_beats);
        int stop_at;
        stop_at = queued_beats + n_beats;
        while (queued_beats < stop_at) add_random_string();
    endtask

    // step just past the rising edge, clear of driver and monitor activity
    task automatic tick();
        @(posedge clk);
        #1;
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_ch.valid || expected_cs.size() != 0) tick();
    endtask

    // ---------------- driver, receiver, monitor ----------------

    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_took) begin
            // beat not taken yet: hold it
        end else if (pending_beats.size() != 0 && !tx_pause &&
                     $urandom_range(0, 99) >= tx_idle) begin
            in_ch.valid     <= 1'b1;
            in_ch.text_byte <= pending_beats[0].b;
            in_ch.is_last   <= pending_beats[0].last;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    always @(posedge clk) begin : monitor
        logic [CS_W-1:0] want;
        in_took = 1'b0;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_cs.size() == 0) begin
                    report_mismatch($sformatf("charset %0d with no string pending",
                                              out_ch.charset));
                end else begin
                    want = expected_cs.pop_front();
                    if (out_ch.charset !== want)
                        report_mismatch($sformatf("charset got %0d, want %0d",
                                                  out_ch.charset, want));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                in_took = 1'b1;
                absorb_byte(in_ch.text_byte, in_ch.is_last);
                pending_beats.pop_front();
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        clear_tracker();
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.text_byte = 8'h00;
        in_ch.is_last   = 1'b0;
        out_ch.ready    = 1'b0;
        tx_idle         = 14;
        rx_idle         = 53;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tick();

        // directed strings: each verdict path at least once
        str_q = '{8'h41};                              commit_string();
        str_q = '{8'h01, 8'hff};                       commit_string();
        str_q = '{BYTE_ESC, BYTE_DOLLAR, BYTE_B, 8'hff};  commit_string();
        str_q = '{BYTE_ESC, BYTE_DOLLAR, BYTE_AT, 8'h80}; commit_string();
        str_q = '{8'h82, 8'ha0};                       commit_string();
        str_q = '{BYTE_SS2, 8'ha1};                    commit_string();
        str_q = '{8'ha4, 8'ha2};                       commit_string();
        str_q = '{8'hc2, 8'ha9};                       commit_string();
        str_q = '{8'he3, 8'h81};                       commit_string();
        str_q = '{8'hf4, 8'h90, 8'h80, 8'h80};         commit_string();
        run_random(150);
        wait_drained();

        tx_idle = 53;
        rx_idle = 14;
        run_random(160);
        wait_drained();

        tx_idle = 0;
        rx_idle = 0;
        // long receiver stall while short strings keep arriving
        hold_req = 1'b1;
        repeat (40) begin
            repeat ($urandom_range(1, 2)) str_q.push_back(rand_byte(1, 255));
            commit_string();
        end
        wait_drained();

        run_random(150);
        while (pending_beats.size() > 75) tick();
        tx_pause = 1'b1;
        while (in_ch.valid || expected_cs.size() != 0) tick();
        repeat (4) tick();
        tx_pause = 1'b0;
        wait_drained();

        repeat (DRAIN_WAIT) tick();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 200000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
